[rtl/uart_baud_divisor_calculator_unit_assert.svh]
// ----------------------------------------------------------------------------
// uart_baud_divisor_calculator_unit_assert.svh
// assertion macros shared by the divisor calculator
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALCULATOR_UNIT_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALCULATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UBDC_ASSERT_IMP(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UBDC_ASSERT_NXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/ubdc_pkg.sv]
// ----------------------------------------------------------------------------
// ubdc_pkg
// types, constants and helper functions of the baud divisor calculator
// ----------------------------------------------------------------------------
package ubdc_pkg;

    // field widths
    localparam int BAUD_W      = 24;
    localparam int CLK_W       = 28;
    localparam int CFG_DATA_W  = 28;
    localparam int MANT_W      = 12;
    localparam int FRAC_W      = 4;
    localparam int WORD_W      = 16;

    // divider widths and step counts
    localparam int NUM_W       = 33;
    localparam int DEN_SMALL_W = 26;
    localparam int DIV1_STEPS  = 33;
    localparam int DIV2_STEPS  = 7;
    localparam int STEPS       = DIV1_STEPS + DIV2_STEPS;

    // arithmetic constants
    localparam int               CLK_SCALE   = 25;
    localparam int               PCT_SCALE   = 100;
    localparam logic [11:0]      FRAC_ROUND  = 12'd50;
    localparam logic [12:0]      RECIP_100   = 13'd5243;  // ceil(2^19 / 100)
    localparam int               RECIP_SHIFT = 19;
    localparam logic [FRAC_W-1:0] FRAC_MASK_16 = 4'h0F;
    localparam logic [FRAC_W-1:0] FRAC_MASK_8  = 4'h07;
    localparam logic [MANT_W-1:0] MANT_MAX     = 12'd4095;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_BUS_CLOCK  = 1'b0,
        REG_OVERSAMPLE = 1'b1
    } t_cfg_idx;

    // payload of one divider step
    typedef struct packed {
        logic [NUM_W-1:0]       rem;
        logic [NUM_W-1:0]       num;
        logic [NUM_W-1:0]       quo;
        logic [NUM_W-1:0]       den;
        logic [DEN_SMALL_W-1:0] den_small;
        logic [MANT_W-1:0]      mant;
        logic                   sat;
        logic                   by8;
        logic                   zero;
    } t_div;

    // hand over from the divide by 100*d to the divide by d
    function automatic t_div ubdc_to_rem(input t_div d);
        t_div r;
        r           = d;
        r.rem       = {{DIV2_STEPS{1'b0}}, d.rem[NUM_W-1:DIV2_STEPS]};
        r.num       = {d.rem[DIV2_STEPS-1:0], {(NUM_W-DIV2_STEPS){1'b0}}};
        r.quo       = '0;
        r.den       = {{(NUM_W-DEN_SMALL_W){1'b0}}, d.den_small};
        r.mant      = d.quo[MANT_W-1:0];
        r.sat       = |d.quo[NUM_W-1:MANT_W];
        return r;
    endfunction

    // rounded fraction from a remainder below 100
    function automatic logic [FRAC_W-1:0] ubdc_frac(input logic [DIV2_STEPS-1:0] rem,
                                                    input logic by8);
        logic [11:0] x;
        logic [24:0] p;
        logic [4:0]  q;
        x = by8 ? ({5'b0, rem} << 3) + FRAC_ROUND : ({5'b0, rem} << 4) + FRAC_ROUND;
        p = 25'(x) * 25'(RECIP_100);
        q = p[RECIP_SHIFT+4:RECIP_SHIFT];
        return by8 ? (q[FRAC_W-1:0] & FRAC_MASK_8) : (q[FRAC_W-1:0] & FRAC_MASK_16);
    endfunction

endpackage

[rtl/ubdc_in_if.sv]
// ----------------------------------------------------------------------------
// ubdc_in_if
// request channel carrying the wanted baud rate
// ----------------------------------------------------------------------------
interface ubdc_in_if import ubdc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink   (input valid, input baud_rate, output ready);
endinterface

[rtl/ubdc_out_if.sv]
// ----------------------------------------------------------------------------
// ubdc_out_if
// result channel carrying the divisor word and its parts
// ----------------------------------------------------------------------------
interface ubdc_out_if import ubdc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] divisor_word;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] fraction;
    logic              range_error;

    modport source (output valid, output divisor_word, output mantissa,
                    output fraction, output range_error, input ready);
    modport sink   (input valid, input divisor_word, input mantissa,
                    input fraction, input range_error, output ready);
endinterface

[rtl/uart_baud_divisor_calculator_unit.sv]
// ----------------------------------------------------------------------------
// uart_baud_divisor_calculator_unit
// baud rate to fractional divisor word, fully pipelined
// ----------------------------------------------------------------------------
// Requests arrive on i_req (valid/ready, baud_rate); each accepted
// transaction yields exactly one result on o_rsp with divisor_word,
// mantissa, fraction and range_error, in request order. Bus clock and
// oversampling mode are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must do so while no request is in flight: the block does not check.
// A new request is taken every cycle while the input stage can move. The
// result passes through 42 register stages: one input stage forming
// 25*clock and 100*k*baud (loaded at the accepting edge), 33 divide steps for
// the mantissa (one quotient bit per stage), 7 divide steps for the
// remainder, and the output stage forming the rounded fraction.
// Every stage has its own valid bit and moves when it is empty or its
// successor moves, so bubbles close up and a stalled o_rsp holds its
// transaction while earlier stages keep filling.
// Synchronous reset empties the pipeline and loads the configuration with
// a 16 MHz bus clock and oversampling by 16.
// ----------------------------------------------------------------------------
`include "uart_baud_divisor_calculator_unit_assert.svh"

module uart_baud_divisor_calculator_unit import ubdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ubdc_in_if.sink               i_req,
    ubdc_out_if.source            o_rsp
);

    logic [CLK_W-1:0]  r_cfg_clk;
    logic              r_cfg_by8;

    logic              r_front_v;
    t_div              r_front;
    t_div              n_front;
    logic              w_front_rdy;

    logic              w_sv [STEPS];
    logic              w_sr [STEPS];
    t_div              w_si [STEPS];
    logic              w_ov [STEPS];
    logic              w_or [STEPS];
    t_div              w_od [STEPS];

    logic              w_out_rdy;
    t_div              w_last;
    logic              r_out_v;
    logic [MANT_W-1:0] r_mant;
    logic [FRAC_W-1:0] r_frac;
    logic              r_err;
    logic [MANT_W-1:0] n_mant;
    logic [FRAC_W-1:0] n_frac;
    logic              n_err;
    logic [DEN_SMALL_W-1:0] w_den;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_clk <= 28'd16000000;
            r_cfg_by8 <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_BUS_CLOCK:  r_cfg_clk <= i_cfg_data[CLK_W-1:0];
                REG_OVERSAMPLE: r_cfg_by8 <= i_cfg_data[0];
                default:        r_cfg_clk <= r_cfg_clk;
            endcase
        end
    end

    // input stage: numerator 25*clock, divisors k*baud and 100*k*baud
    always_comb begin
        w_den = r_cfg_by8 ? {1'b0, i_req.baud_rate, 1'b0} : {i_req.baud_rate, 2'b00};
        n_front           = '0;
        n_front.num       = NUM_W'(r_cfg_clk) * NUM_W'(CLK_SCALE);
        n_front.den       = NUM_W'(w_den) * NUM_W'(PCT_SCALE);
        n_front.den_small = w_den;
        n_front.by8       = r_cfg_by8;
        n_front.zero      = (i_req.baud_rate == '0);
    end

    assign w_front_rdy = !r_front_v || w_sr[0];
    assign i_req.ready = w_front_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_v <= 1'b0;
        end else if (w_front_rdy) begin
            r_front_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_front_rdy && i_req.valid) begin
            r_front <= n_front;
        end
    end

    // divide steps: mantissa bits, then remainder bits
    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            if (k == 0) begin : g_first
                assign w_sv[k] = r_front_v;
                assign w_si[k] = r_front;
            end else if (k == DIV1_STEPS) begin : g_handover
                assign w_sv[k] = w_ov[k-1];
                assign w_si[k] = ubdc_to_rem(w_od[k-1]);
            end else begin : g_mid
                assign w_sv[k] = w_ov[k-1];
                assign w_si[k] = w_od[k-1];
            end

            if (k == STEPS - 1) begin : g_tail
                assign w_or[k] = w_out_rdy;
            end else begin : g_link
                assign w_or[k] = w_sr[k+1];
            end

            ubdc_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_sv[k]),
                .o_ready (w_sr[k]),
                .i_data  (w_si[k]),
                .o_valid (w_ov[k]),
                .i_ready (w_or[k]),
                .o_data  (w_od[k])
            );
        end
    endgenerate

    // output stage: saturation, error flag and rounded fraction
    assign w_last = w_od[STEPS-1];

    always_comb begin
        if (w_last.zero) begin
            n_mant = MANT_MAX;
            n_frac = '0;
            n_err  = 1'b1;
        end else begin
            n_mant = w_last.sat ? MANT_MAX : w_last.mant;
            n_frac = ubdc_frac(w_last.quo[DIV2_STEPS-1:0], w_last.by8);
            n_err  = w_last.sat;
        end
    end

    assign w_out_rdy = !r_out_v || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_v <= w_ov[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_ov[STEPS-1]) begin
            r_mant <= n_mant;
            r_frac <= n_frac;
            r_err  <= n_err;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.mantissa     = r_mant;
    assign o_rsp.fraction     = r_frac;
    assign o_rsp.range_error  = r_err;
    assign o_rsp.divisor_word = {r_mant, r_frac};

    // checks
    `UBDC_ASSERT_IMP(a_err_only_when_saturated,
        o_rsp.valid && (o_rsp.mantissa != MANT_MAX), !o_rsp.range_error,
        "range error without saturated mantissa")
    `UBDC_ASSERT_IMP(a_frac_three_bits_by8,
        o_rsp.valid && r_cfg_by8, o_rsp.fraction[3] == 1'b0,
        "fraction uses bit 3 while oversampling by 8")
    `UBDC_ASSERT_NXT(a_zero_baud_flagged,
        i_req.valid && i_req.ready && (i_req.baud_rate == '0), r_front_v && r_front.zero,
        "zero baud transaction not flagged at input stage")
    `UBDC_ASSERT_NXT(a_front_holds_on_stall,
        r_front_v && !w_sr[0], r_front_v,
        "input stage lost a stalled transaction")

endmodule

[rtl/ubdc_div_step.sv]
// ----------------------------------------------------------------------------
// ubdc_div_step
// one restoring division step (one quotient bit) with its pipeline register
// ----------------------------------------------------------------------------
module ubdc_div_step import ubdc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_data
);

    logic             r_valid;
    t_div             r_data;
    t_div             n_data;
    logic [NUM_W:0]   w_shift;
    logic [NUM_W+1:0] w_diff;
    logic             w_ge;

    // shift in next dividend bit, trial subtract
    always_comb begin
        w_shift = {i_data.rem, i_data.num[NUM_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b0, i_data.den};
        w_ge    = !w_diff[NUM_W+1];
        n_data      = i_data;
        n_data.rem  = w_ge ? w_diff[NUM_W-1:0] : w_shift[NUM_W-1:0];
        n_data.num  = {i_data.num[NUM_W-2:0], 1'b0};
        n_data.quo  = {i_data.quo[NUM_W-2:0], w_ge};
    end

    // stage moves when empty or when downstream takes its transaction
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the baud divisor calculator against a cycle-free predictor. Phases of
// requests run under several bus clock and oversampling settings, with random
// gaps on the request side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import ubdc_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 6;
    localparam int LATENCY    = 42;
    localparam int CYCLE_CAP  = 200000;
    localparam int PHASES     = 10;
    localparam int PER_PHASE  = 110;

    // one divisor result, compared field by field
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [MANT_W-1:0] mant;
        logic [FRAC_W-1:0] frac;
        logic              err;
    } divisor_result_t;

    // expected divisors and the bus clock / oversampling copy they are computed from
    class divisor_scoreboard;
        logic [CLK_W-1:0] bus_clock;
        logic             by8;
        divisor_result_t  expected_divisors[$];
        int               mismatch_count;

        function new();
            bus_clock      = 28'd16000000;
            by8            = 1'b0;
            mismatch_count = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_BUS_CLOCK) begin
                bus_clock = data[CLK_W-1:0];
            end else begin
                by8 = data[0];
            end
        endfunction

        function divisor_result_t predict_divisor(logic [BAUD_W-1:0] baud);
            divisor_result_t  r;
            longint unsigned  denom;
            longint unsigned  scaled;
            longint unsigned  full;
            longint unsigned  rem;
            longint unsigned  frac;
            r.err = 1'b0;
            if (baud == '0) begin
                // infinite divider
                r.mant = MANT_MAX;
                r.frac = '0;
                r.err  = 1'b1;
            end else begin
                denom  = (by8 ? 64'd2 : 64'd4) * longint'(baud);
                scaled = (CLK_SCALE * longint'(bus_clock)) / denom;
                full   = scaled / PCT_SCALE;
                rem    = scaled - full * PCT_SCALE;
                // carry out of the rounded fraction is dropped by the mask
                if (by8) begin
                    frac = ((rem * 8 + FRAC_ROUND) / PCT_SCALE) & FRAC_MASK_8;
                end else begin
                    frac = ((rem * 16 + FRAC_ROUND) / PCT_SCALE) & FRAC_MASK_16;
                end
                r.frac = frac[FRAC_W-1:0];
                if (full > MANT_MAX) begin
                    r.mant = MANT_MAX;
                    r.err  = 1'b1;
                end else begin
                    r.mant = full[MANT_W-1:0];
                end
            end
            r.word = {r.mant, r.frac};
            return r;
        endfunction

        function void note_baud_request(logic [BAUD_W-1:0] baud);
            expected_divisors.push_back(predict_divisor(baud));
        endfunction

        function int pending();
            return expected_divisors.size();
        endfunction

        function void check_divisor_result(divisor_result_t got);
            divisor_result_t exp;
            if (expected_divisors.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got.word);
                mismatch_count++;
                return;
            end
            exp = expected_divisors.pop_front();
            if (got.word !== exp.word) begin
                $display("%0t: divisor_word expected %h actual %h", $time, exp.word, got.word);
                mismatch_count++;
            end
            if (got.mant !== exp.mant) begin
                $display("%0t: mantissa expected %h actual %h", $time, exp.mant, got.mant);
                mismatch_count++;
            end
            if (got.frac !== exp.frac) begin
                $display("%0t: fraction expected %h actual %h", $time, exp.frac, got.frac);
                mismatch_count++;
            end
            if (got.err !== exp.err) begin
                $display("%0t: range_error expected %b actual %b", $time, exp.err, got.err);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ubdc_in_if  req_if ();
    ubdc_out_if rsp_if ();

    uart_baud_divisor_calculator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    divisor_scoreboard divisor_sb = new();
    logic              gap_on;
    logic              stall_on;
    int                cycle_count;

    // clock
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            divisor_sb.check_divisor_result({rsp_if.divisor_word, rsp_if.mantissa,
                                             rsp_if.fraction, rsp_if.range_error});
        end
    end

    // result back-pressure in random bursts
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
        end
    end

    // register write, called at a falling edge
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        divisor_sb.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // one request transaction, called at a falling edge, returns at a falling edge
    task automatic send_baud(input logic [BAUD_W-1:0] baud);
        if (gap_on && $urandom_range(0, 2) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        req_if.valid     = 1'b1;
        req_if.baud_rate = baud;
        do @(posedge i_clk); while (!req_if.ready);
        divisor_sb.note_baud_request(baud);
        @(negedge i_clk);
    endtask

    // mix of tiny rates (saturation), standard rates, and the full field
    function automatic logic [BAUD_W-1:0] random_baud();
        logic [BAUD_W-1:0] std_rates[11];
        std_rates = '{24'd1200, 24'd2400, 24'd4800, 24'd9600, 24'd19200, 24'd38400,
                      24'd57600, 24'd115200, 24'd230400, 24'd460800, 24'd921600};
        case ($urandom_range(0, 9))
            0, 1:    return BAUD_W'($urandom_range(0, 300));
            2:       return BAUD_W'($urandom_range(0, 4095));
            3, 4, 5: return std_rates[$urandom_range(0, 10)];
            6, 7:    return BAUD_W'($urandom_range(1, 16000000));
            8:       return BAUD_W'($urandom);
            default: return BAUD_W'($urandom_range(300, 921600));
        endcase
    endfunction

    // main sequence
    initial begin
        logic [BAUD_W-1:0] directed[16];
        logic [CLK_W-1:0]  phase_clock[PHASES];
        logic              phase_by8[PHASES];

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_BUS_CLOCK;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.baud_rate = '0;
        gap_on           = 1'b0;
        stall_on         = 1'b0;

        // zero, extremes, saturation boundary, and a fraction that rounds up to 16
        directed = '{24'd0, 24'd1, 24'd2, 24'd16000000, 24'hFFFFFF, 24'h800000,
                     24'd9600, 24'd115200, 24'd2400, 24'd244, 24'd245, 24'd921600,
                     24'd101, 24'd1032, 24'h555555, 24'hAAAAAA};

        phase_clock = '{28'd16000000, 28'd171798691, 28'd1, 28'd0, 28'hFFFFFFF,
                        28'hFFFFFFF, 28'd16000000, 28'd0, 28'd0, 28'd0};
        phase_by8   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
        phase_clock[7] = CLK_W'($urandom_range(1, 171798691));
        phase_clock[8] = CLK_W'($urandom_range(1, 1000));
        phase_clock[9] = CLK_W'($urandom_range(1, 171798691));
        phase_by8[7]   = 1'($urandom);
        phase_by8[8]   = 1'($urandom);
        phase_by8[9]   = 1'($urandom);

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            // reconfigure only with the pipeline drained
            if (p > 0) begin
                while (divisor_sb.pending() != 0) @(posedge i_clk);
                @(negedge i_clk);
                write_register(REG_BUS_CLOCK, phase_clock[p]);
                write_register(REG_OVERSAMPLE, {27'($urandom), phase_by8[p]});
            end
            gap_on   = (p != 4) && (p != PHASES - 1);
            stall_on = gap_on;
            if (p == 0) begin
                foreach (directed[i]) send_baud(directed[i]);
            end
            repeat (PER_PHASE) send_baud(random_baud());
            req_if.valid = 1'b0;
        end

        // drain and let the pipeline settle
        while (divisor_sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (divisor_sb.mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
